// ===== hw/rtl/mwa_pkg.sv =====
`default_nettype none
package mwa_pkg;

   localparam int IDX_BITS    = 7;
   localparam int WGT_IN_BITS = 16;
   localparam int LABEL_BITS  = 32;
   localparam int TOTAL_BITS  = 22;

   localparam logic [LABEL_BITS-1:0] SLACK_INIT = LABEL_BITS'(1 << 28);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [IDX_BITS-1:0]    row;
      logic [IDX_BITS-1:0]    col;
      logic [WGT_IN_BITS-1:0] weight;
   } request_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   column;
      logic [IDX_BITS-1:0]   matched_row;
      logic [TOTAL_BITS-1:0] total_weight;
      logic                  last;
   } response_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] row;
      logic [IDX_BITS-1:0] col;
   } stack_entry_type;

endpackage
`default_nettype wire

// ===== hw/rtl/mwa_ram.sv =====
`default_nettype none
module mwa_ram #(
   parameter int WIDTH     = 16,
   parameter int ADDR_BITS = 6
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mwa_ctrl.sv =====
`default_nettype none
module mwa_ctrl #(
   parameter int MAX_SIZE    = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [mwa_pkg::IDX_BITS-1:0]   size,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire mwa_pkg::request_type           req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output mwa_pkg::response_type               rsp
);
   import mwa_pkg::*;

   localparam int IW = $clog2(MAX_SIZE);
   localparam int LA = IW + 1;
   localparam int WA = 2 * IW;
   localparam int SW = 2 * IDX_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_CLR, S_MAX_RD, S_MAX_CMP, S_ROW_START, S_TOP_RD, S_TOP_GET,
      S_LAB_RD, S_LAB_GET, S_SCAN, S_SCAN_CMP, S_OWN_GET, S_AUG_RD, S_AUG_WR,
      S_RL_INIT, S_RL_ROW, S_RL_RLAB, S_RL_COL, S_RL_CMP, S_UP_SEL, S_UP_WR,
      S_TOT_RD, S_TOT_ADD, S_OUT_RD, S_OUT_SEND, S_OUT_WAIT
   } state_type;

   function automatic logic [IW-1:0] ix(input logic [IDX_BITS-1:0] a);
      logic [IDX_BITS-1:0] d;
      d = a - IDX_BITS'(1);
      return d[IW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [IDX_BITS-1:0]   i_ff, i_in, j_ff, j_in, u_ff, u_in, v_ff, v_in;
   logic [IDX_BITS-1:0]   depth_ff, depth_in;
   logic                  side_ff, side_in;
   logic [LABEL_BITS-1:0] lab_u_ff, lab_u_in, acc_ff, acc_in;
   logic [MAX_SIZE-1:0]   rseen_ff, rseen_in, cseen_ff, cseen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   response_type          rsp_ff, rsp_in;

   logic                   w_we;
   logic [WA-1:0]          w_waddr, w_raddr;
   logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
   logic                   lab_we;
   logic [LA-1:0]          lab_waddr, lab_raddr;
   logic [LABEL_BITS-1:0]  lab_wdata, lab_rdata;
   logic                   own_we;
   logic [IW-1:0]          own_waddr, own_raddr;
   logic [IDX_BITS-1:0]    own_wdata, own_rdata;
   logic                   stk_we;
   logic [IW-1:0]          stk_waddr, stk_raddr;
   stack_entry_type        stk_wdata, stk_rdata;
   logic [SW-1:0]          stk_rdata_raw;

   logic [LABEL_BITS-1:0] w_ext, eq_sum, slack;
   logic                  row_ok, col_ok;

   mwa_ram #(.WIDTH(WEIGHT_BITS), .ADDR_BITS(WA)) u_weight (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .raddr(w_raddr), .rdata(w_rdata));
   mwa_ram #(.WIDTH(LABEL_BITS), .ADDR_BITS(LA)) u_label (
      .clock(clock), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
      .raddr(lab_raddr), .rdata(lab_rdata));
   mwa_ram #(.WIDTH(IDX_BITS), .ADDR_BITS(IW)) u_owner (
      .clock(clock), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
      .raddr(own_raddr), .rdata(own_rdata));
   mwa_ram #(.WIDTH(SW), .ADDR_BITS(IW)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(SW'(stk_wdata)),
      .raddr(stk_raddr), .rdata(stk_rdata_raw));

   assign stk_rdata = stack_entry_type'(stk_rdata_raw);
   assign w_ext     = LABEL_BITS'(w_rdata);
   assign eq_sum    = lab_u_ff + lab_rdata;
   assign slack     = lab_u_ff + lab_rdata - w_ext;
   assign row_ok    = (req.row != '0) && (req.row <= IDX_BITS'(MAX_SIZE));
   assign col_ok    = (req.col != '0) && (req.col <= IDX_BITS'(MAX_SIZE));

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      depth_in     = depth_ff;
      side_in      = side_ff;
      lab_u_in     = lab_u_ff;
      acc_in       = acc_ff;
      rseen_in     = rseen_ff;
      cseen_in     = cseen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      w_we      = 1'b0;
      w_waddr   = {ix(req.row), ix(req.col)};
      w_wdata   = WEIGHT_BITS'(req.weight);
      w_raddr   = {ix(u_ff), ix(v_ff)};
      lab_we    = 1'b0;
      lab_waddr = {side_ff, ix(u_ff)};
      lab_wdata = '0;
      lab_raddr = {1'b1, ix(v_ff)};
      own_we    = 1'b0;
      own_waddr = ix(j_ff);
      own_wdata = '0;
      own_raddr = ix(v_ff);
      stk_we    = 1'b0;
      stk_waddr = ix(depth_ff);
      stk_wdata = '{row: u_ff, col: v_ff};
      stk_raddr = ix(depth_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req.kind == KIND_WRITE) begin
                  w_we = row_ok && col_ok;
               end else begin
                  j_in     = IDX_BITS'(1);
                  state_in = S_CLR;
               end
            end
         end
         S_CLR: begin
            lab_we    = 1'b1;
            lab_waddr = {1'b1, ix(j_ff)};
            own_we    = 1'b1;
            if (j_ff == size) begin
               i_in     = IDX_BITS'(1);
               j_in     = IDX_BITS'(1);
               acc_in   = '0;
               state_in = S_MAX_RD;
            end else begin
               j_in = j_ff + IDX_BITS'(1);
            end
         end
         S_MAX_RD: begin
            w_raddr  = {ix(i_ff), ix(j_ff)};
            state_in = S_MAX_CMP;
         end
         S_MAX_CMP: begin
            acc_in   = (w_ext > acc_ff) ? w_ext : acc_ff;
            state_in = S_MAX_RD;
            if (j_ff == size) begin
               lab_we    = 1'b1;
               lab_waddr = {1'b0, ix(i_ff)};
               lab_wdata = acc_in;
               acc_in    = '0;
               j_in      = IDX_BITS'(1);
               if (i_ff == size) begin
                  i_in     = IDX_BITS'(1);
                  state_in = S_ROW_START;
               end else begin
                  i_in = i_ff + IDX_BITS'(1);
               end
            end else begin
               j_in = j_ff + IDX_BITS'(1);
            end
         end
         S_ROW_START: begin
            rseen_in         = '0;
            rseen_in[ix(i_ff)] = 1'b1;
            cseen_in         = '0;
            stk_we           = 1'b1;
            stk_waddr        = '0;
            stk_wdata        = '{row: i_ff, col: IDX_BITS'(1)};
            depth_in         = IDX_BITS'(1);
            u_in             = i_ff;
            v_in             = IDX_BITS'(1);
            state_in         = S_LAB_RD;
         end
         S_TOP_RD: begin
            stk_raddr = ix(depth_ff);
            state_in  = S_TOP_GET;
         end
         S_TOP_GET: begin
            // resume the parent row one column past its last match
            u_in     = stk_rdata.row;
            v_in     = stk_rdata.col + IDX_BITS'(1);
            state_in = S_LAB_RD;
         end
         S_LAB_RD: begin
            lab_raddr = {1'b0, ix(u_ff)};
            state_in  = S_LAB_GET;
         end
         S_LAB_GET: begin
            lab_u_in = lab_rdata;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (v_ff > size) begin
               depth_in = depth_ff - IDX_BITS'(1);
               state_in = (depth_ff == IDX_BITS'(1)) ? S_RL_INIT : S_TOP_RD;
            end else if (cseen_ff[ix(v_ff)]) begin
               v_in = v_ff + IDX_BITS'(1);
            end else begin
               lab_raddr = {1'b1, ix(v_ff)};
               w_raddr   = {ix(u_ff), ix(v_ff)};
               state_in  = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (eq_sum == w_ext) begin
               cseen_in[ix(v_ff)] = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = ix(depth_ff);
               own_raddr = ix(v_ff);
               state_in  = S_OWN_GET;
            end else begin
               v_in     = v_ff + IDX_BITS'(1);
               state_in = S_SCAN;
            end
         end
         S_OWN_GET: begin
            if (own_rdata == '0) begin
               j_in     = depth_ff;
               state_in = S_AUG_RD;
            end else if (depth_ff < IDX_BITS'(MAX_SIZE)) begin
               rseen_in[ix(own_rdata)] = 1'b1;
               stk_we    = 1'b1;
               stk_waddr = depth_ff[IW-1:0];
               stk_wdata = '{row: own_rdata, col: IDX_BITS'(1)};
               depth_in  = depth_ff + IDX_BITS'(1);
               u_in      = own_rdata;
               v_in      = IDX_BITS'(1);
               state_in  = S_LAB_RD;
            end else begin
               v_in     = v_ff + IDX_BITS'(1);
               state_in = S_SCAN;
            end
         end
         S_AUG_RD: begin
            stk_raddr = ix(j_ff);
            state_in  = S_AUG_WR;
         end
         S_AUG_WR: begin
            own_we    = 1'b1;
            own_waddr = ix(stk_rdata.col);
            own_wdata = stk_rdata.row;
            if (j_ff == IDX_BITS'(1)) begin
               if (i_ff == size) begin
                  j_in     = IDX_BITS'(1);
                  side_in  = 1'b0;
                  acc_in   = '0;
                  state_in = S_TOT_RD;
               end else begin
                  i_in     = i_ff + IDX_BITS'(1);
                  state_in = S_ROW_START;
               end
            end else begin
               j_in     = j_ff - IDX_BITS'(1);
               state_in = S_AUG_RD;
            end
         end
         S_RL_INIT: begin
            acc_in   = SLACK_INIT;
            u_in     = IDX_BITS'(1);
            state_in = S_RL_ROW;
         end
         S_RL_ROW: begin
            if (u_ff > size) begin
               u_in     = IDX_BITS'(1);
               side_in  = 1'b0;
               state_in = S_UP_SEL;
            end else if (!rseen_ff[ix(u_ff)]) begin
               u_in = u_ff + IDX_BITS'(1);
            end else begin
               lab_raddr = {1'b0, ix(u_ff)};
               state_in  = S_RL_RLAB;
            end
         end
         S_RL_RLAB: begin
            lab_u_in = lab_rdata;
            v_in     = IDX_BITS'(1);
            state_in = S_RL_COL;
         end
         S_RL_COL: begin
            if (v_ff > size) begin
               u_in     = u_ff + IDX_BITS'(1);
               state_in = S_RL_ROW;
            end else if (cseen_ff[ix(v_ff)]) begin
               v_in = v_ff + IDX_BITS'(1);
            end else begin
               lab_raddr = {1'b1, ix(v_ff)};
               w_raddr   = {ix(u_ff), ix(v_ff)};
               state_in  = S_RL_CMP;
            end
         end
         S_RL_CMP: begin
            if ($signed(slack) < $signed(acc_ff)) begin
               acc_in = slack;
            end
            v_in     = v_ff + IDX_BITS'(1);
            state_in = S_RL_COL;
         end
         S_UP_SEL: begin
            if (u_ff > size) begin
               u_in = IDX_BITS'(1);
               if (side_ff) begin
                  state_in = S_ROW_START;
               end else begin
                  side_in = 1'b1;
               end
            end else if (side_ff ? cseen_ff[ix(u_ff)] : rseen_ff[ix(u_ff)]) begin
               lab_raddr = {side_ff, ix(u_ff)};
               state_in  = S_UP_WR;
            end else begin
               u_in = u_ff + IDX_BITS'(1);
            end
         end
         S_UP_WR: begin
            // lower seen rows, raise seen columns by the minimum slack
            lab_we    = 1'b1;
            lab_waddr = {side_ff, ix(u_ff)};
            lab_wdata = side_ff ? (lab_rdata + acc_ff) : (lab_rdata - acc_ff);
            u_in      = u_ff + IDX_BITS'(1);
            state_in  = S_UP_SEL;
         end
         S_TOT_RD: begin
            lab_raddr = {side_ff, ix(j_ff)};
            state_in  = S_TOT_ADD;
         end
         S_TOT_ADD: begin
            acc_in   = acc_ff + lab_rdata;
            side_in  = !side_ff;
            state_in = S_TOT_RD;
            if (side_ff) begin
               if (j_ff == size) begin
                  j_in     = IDX_BITS'(1);
                  state_in = S_OUT_RD;
               end else begin
                  j_in = j_ff + IDX_BITS'(1);
               end
            end
         end
         S_OUT_RD: begin
            own_raddr = ix(j_ff);
            state_in  = S_OUT_SEND;
         end
         S_OUT_SEND: begin
            rsp_in.column       = j_ff;
            rsp_in.matched_row  = own_rdata;
            rsp_in.total_weight = acc_ff[TOTAL_BITS-1:0];
            rsp_in.last         = (j_ff == size);
            rsp_valid_in        = 1'b1;
            state_in            = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + IDX_BITS'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rseen_ff     <= '0;
         cseen_ff     <= '0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rseen_ff     <= rseen_in;
         cseen_ff     <= cseen_in;
         depth_ff     <= depth_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      side_ff  <= side_in;
      lab_u_ff <= lab_u_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/max_weight_assignment.sv =====
// Weight write requests: accepted one per cycle while idle, no result.
// Start request: label setup, then per row a depth-first search per attempt
// and a relabel pass per failed attempt (one weight/label memory read per
// step), an augment along the path, a sum of the labels for the total and
// one result per column. Reset is synchronous: size returns to 1.
`default_nettype none
module max_weight_assignment #(
   parameter int MAX_SIZE    = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // row[6:0], col[13:7], weight[29:14]
   input  wire logic        req_tuser,  // kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // column[6:0], matched_row[13:7], total[35:14]
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data
);
   import mwa_pkg::*;

   logic [IDX_BITS-1:0] size_ff, size_in;
   request_type         req;
   response_type        rsp;

   always_comb begin
      size_in = size_ff;
      if (csr_valid) begin
         if (csr_data == '0) begin
            size_in = IDX_BITS'(1);
         end else if (csr_data > IDX_BITS'(MAX_SIZE)) begin
            size_in = IDX_BITS'(MAX_SIZE);
         end else begin
            size_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= IDX_BITS'(1);
      end else begin
         size_ff <= size_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req.kind   = req_tuser;
   assign req.row    = req_tdata[6:0];
   assign req.col    = req_tdata[13:7];
   assign req.weight = req_tdata[29:14];

   mwa_ctrl #(.MAX_SIZE(MAX_SIZE), .WEIGHT_BITS(WEIGHT_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .size(size_ff),
      .req_valid(req_tvalid), .req_ready(req_tready), .req(req),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp));

   assign rsp_tdata = {4'b0, rsp.total_weight, rsp.matched_row, rsp.column};
   assign rsp_tlast = rsp.last;

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (size_ff != '0) && (size_ff <= IDX_BITS'(MAX_SIZE)))
      else $error("matrix size out of range");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result after final column");

endmodule
`default_nettype wire

// ===== verif/max_weight_assignment_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module max_weight_assignment_tb;
   import mwa_pkg::*;

   localparam int DIM = 64;

   typedef struct {
      logic [IDX_BITS-1:0]   column;
      logic [IDX_BITS-1:0]   matched_row;
      logic [TOTAL_BITS-1:0] total_weight;
      logic                  last;
   } match_result_type;

   class assignment_scoreboard;
      bit [WGT_IN_BITS-1:0] weights[DIM*DIM];
      int unsigned n_active;
      longint row_lbl[DIM+1];
      longint col_lbl[DIM+1];
      int     owner[DIM+1];
      bit     row_hit[DIM+1];
      bit     col_hit[DIM+1];
      int     path_row[DIM];
      int     path_col[DIM];
      match_result_type pending[$];
      int errors;

      function new();
         n_active = 1;
         errors   = 0;
      endfunction

      function void set_size(logic [6:0] value);
         int unsigned v;
         v = value;
         if (v < 1) v = 1;
         if (v > DIM) v = DIM;
         n_active = v;
      endfunction

      function longint wt(int r, int c);
         return longint'(weights[(r-1)*DIM + (c-1)]);
      endfunction

      function bit augment(int start);
         int depth, u, v, k;
         bit pushed;
         depth = 1;
         path_row[0] = start;
         path_col[0] = 1;
         row_hit[start] = 1;
         while (depth > 0) begin
            u = path_row[depth-1];
            v = path_col[depth-1];
            pushed = 0;
            for (; v <= n_active; v++) begin
               if (col_hit[v] || row_lbl[u] + col_lbl[v] != wt(u, v)) continue;
               col_hit[v] = 1;
               path_col[depth-1] = v;
               if (owner[v] == 0) begin
                  for (k = depth; k > 0; k--) owner[path_col[k-1]] = path_row[k-1];
                  return 1;
               end
               if (depth < DIM) begin
                  row_hit[owner[v]] = 1;
                  path_row[depth] = owner[v];
                  path_col[depth] = 1;
                  depth++;
                  pushed = 1;
                  break;
               end
            end
            if (pushed) continue;
            depth--;
            if (depth > 0) path_col[depth-1]++;
         end
         return 0;
      endfunction

      function void shift_labels();
         longint delta, s;
         delta = longint'(SLACK_INIT);
         for (int i = 1; i <= n_active; i++) begin
            if (!row_hit[i]) continue;
            for (int j = 1; j <= n_active; j++) begin
               if (col_hit[j]) continue;
               s = row_lbl[i] + col_lbl[j] - wt(i, j);
               if (s < delta) delta = s;
            end
         end
         for (int i = 1; i <= n_active; i++) if (row_hit[i]) row_lbl[i] -= delta;
         for (int j = 1; j <= n_active; j++) if (col_hit[j]) col_lbl[j] += delta;
      endfunction

      function void note_request(request_type rq);
         longint m, total;
         match_result_type e;
         if (rq.kind == KIND_WRITE) begin
            if (rq.row >= 1 && rq.row <= DIM && rq.col >= 1 && rq.col <= DIM)
               weights[(rq.row-1)*DIM + (rq.col-1)] = rq.weight;
            return;
         end
         for (int j = 0; j <= DIM; j++) begin
            owner[j] = 0;
            col_lbl[j] = 0;
         end
         for (int i = 1; i <= n_active; i++) begin
            m = -longint'(SLACK_INIT);
            for (int j = 1; j <= n_active; j++) if (wt(i, j) > m) m = wt(i, j);
            row_lbl[i] = m;
         end
         for (int i = 1; i <= n_active; i++) begin
            forever begin
               for (int k = 0; k <= DIM; k++) begin
                  row_hit[k] = 0;
                  col_hit[k] = 0;
               end
               if (augment(i)) break;
               shift_labels();
            end
         end
         total = 0;
         for (int i = 1; i <= n_active; i++) total += row_lbl[i] + col_lbl[i];
         for (int j = 1; j <= n_active; j++) begin
            e.column       = IDX_BITS'(j);
            e.matched_row  = IDX_BITS'(owner[j]);
            e.total_weight = total[TOTAL_BITS-1:0];
            e.last         = (j == n_active);
            pending.push_back(e);
         end
      endfunction

      function void check_result(match_result_type got);
         match_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result column=%0d row=%0d total=%0d last=%0d",
                     $time, got.column, got.matched_row, got.total_weight, got.last);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.column !== e.column) begin
            $display("%0t: column expected %0d actual %0d", $time, e.column, got.column);
            errors++;
         end
         if (got.matched_row !== e.matched_row) begin
            $display("%0t: matched_row expected %0d actual %0d (column %0d)",
                     $time, e.matched_row, got.matched_row, e.column);
            errors++;
         end
         if (got.total_weight !== e.total_weight) begin
            $display("%0t: total_weight expected %0d actual %0d",
                     $time, e.total_weight, got.total_weight);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last expected %0d actual %0d (column %0d)",
                     $time, e.last, got.last, e.column);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   assignment_scoreboard board = new();
   int  sent_count = 0;
   bit  quiet = 0;
   int  stall_left = 0;
   match_result_type seen;

   max_weight_assignment dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 10) - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.column       = rsp_tdata[6:0];
         seen.matched_row  = rsp_tdata[13:7];
         seen.total_weight = rsp_tdata[35:14];
         seen.last         = rsp_tlast;
         board.check_result(seen);
      end
   end

   task automatic send_request(logic kind, logic [6:0] r, logic [6:0] c, logic [15:0] w);
      request_type rq;
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, w, c, r};
      do @(posedge clock); while (!req_tready);
      rq.kind = kind;
      rq.row = r;
      rq.col = c;
      rq.weight = w;
      board.note_request(rq);
      sent_count++;
   endtask

   task automatic start_match();
      send_request(KIND_START, 7'($urandom), 7'($urandom), 16'($urandom));
   endtask

   // hold the sender until every expected result is in, then settle
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_size(logic [6:0] value);
      drain();
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_size(value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // low ranges give ties and force label updates
   task automatic load_matrix(int n, int hi);
      for (int r = 1; r <= n; r++)
         for (int c = 1; c <= n; c++)
            send_request(KIND_WRITE, 7'(r), 7'(c), 16'($urandom_range(0, hi)));
   endtask

   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default size 1, weight extremes, ignored writes
      send_request(KIND_WRITE, 1, 1, 16'hFFFF);
      start_match();
      send_request(KIND_WRITE, 0, 1, 16'h1234);
      send_request(KIND_WRITE, 1, 0, 16'h1234);
      send_request(KIND_WRITE, 7'd127, 7'd127, 16'h5555);
      send_request(KIND_WRITE, 7'd65, 1, 16'hAAAA);
      send_request(KIND_WRITE, 1, 1, 16'h0000);
      start_match();
      write_size(7'd0);
      start_match();
      write_size(7'd2);
      send_request(KIND_WRITE, 1, 1, 5);
      send_request(KIND_WRITE, 1, 2, 5);
      send_request(KIND_WRITE, 2, 1, 5);
      send_request(KIND_WRITE, 2, 2, 0);
      start_match();
      write_size(7'd3);
      load_matrix(3, 2);
      start_match();
      start_match();

      // random phases of small sizes
      while (sent_count < 220) begin
         if (sent_count > 170) quiet = 1;
         n = $urandom_range(1, 6);
         write_size(7'(n));
         load_matrix(n, ($urandom_range(0, 1) != 0) ? 3 : 65535);
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1) != 0)
               send_request(KIND_WRITE, 7'($urandom_range(0, 127)),
                            7'($urandom_range(0, 127)), 16'($urandom));
            else
               send_request(KIND_WRITE, 7'($urandom_range(1, n)),
                            7'($urandom_range(1, n)), 16'($urandom));
         end
         start_match();
         if ($urandom_range(0, 2) == 0) start_match();
      end

      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
